FILE: sv/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants of the text console cursor writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tccw_pkg;

    localparam int SCREEN_COLUMNS_DEFAULT = 80;
    localparam int SCREEN_ROWS_DEFAULT    = 25;

    localparam int CMD_W   = 2;
    localparam int INDEX_W = 12;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 8;
    localparam int BYTE_W  = 8;
    localparam int ATTR_W  = 4;

    // Wide enough for the largest row times columns plus column before masking.
    localparam int ADDR_CALC_W = ROW_W + COL_W + 1;

    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SCROLL = 2'd2;

    localparam logic [ATTR_W-1:0] ATTR_TEXT  = 4'hF;
    localparam logic [ATTR_W-1:0] ATTR_BLANK = 4'h0;

    localparam logic [BYTE_W-1:0] BYTE_ESC     = 8'h1B;
    localparam logic [BYTE_W-1:0] BYTE_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] BYTE_CURSOR  = 8'h5F;
    localparam logic [BYTE_W-1:0] BYTE_BRACKET = 8'h5B;
    localparam logic [BYTE_W-1:0] BYTE_LETTER_G = 8'h47;
    localparam logic [BYTE_W-1:0] BYTE_LETTER_K = 8'h4B;

    localparam logic [COL_W-1:0] COL_MAX = 8'hFF;

    typedef enum logic [1:0] {
        PHASE_IDLE    = 2'd0,
        PHASE_ESC     = 2'd1,
        PHASE_BRACKET = 2'd2
    } phase_t;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [INDEX_W-1:0] cell_index;
        logic [ROW_W-1:0]   row_number;
        logic [COL_W-1:0]   column_number;
        logic [BYTE_W-1:0]  glyph_code;
        logic [ATTR_W-1:0]  color_attribute;
        logic               last_of_run;
    } cmd_t;

endpackage

`default_nettype wire

FILE: sv/text_console_cursor_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_cursor_writer_top
// Turns a text byte stream into cell write, row clear and scroll commands.
// ----------------------------------------------------------------------------
// Each accepted byte is held in an input register until the result register
// is free, then turned in a single step into its run of zero to three memory
// commands, which are loaded into a three-entry result register and handed
// out one per cycle while out_ready is high. Printable text and newlines that
// scroll cause three commands, other newlines and row clears two, and the
// remaining bytes one or none; the single output channel sets the byte rate,
// which reaches up to one byte per cycle for bytes that cause one or no
// command while out_ready stays high. The next byte is taken into the input
// register while the previous run is still draining. Cursor column, row and
// escape phase update as each byte leaves the input register.
`default_nettype none

module text_console_cursor_writer_top #(
    parameter int SCREEN_COLUMNS = tccw_pkg::SCREEN_COLUMNS_DEFAULT,
    parameter int SCREEN_ROWS    = tccw_pkg::SCREEN_ROWS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          in_valid,
    output      logic                          in_ready,
    input  wire logic [tccw_pkg::BYTE_W-1:0]   char_byte,

    output      logic                          out_valid,
    input  wire logic                          out_ready,
    output      logic [tccw_pkg::CMD_W-1:0]    command,
    output      logic [tccw_pkg::INDEX_W-1:0]  cell_index,
    output      logic [tccw_pkg::ROW_W-1:0]    row_number,
    output      logic [tccw_pkg::COL_W-1:0]    column_number,
    output      logic [tccw_pkg::BYTE_W-1:0]   glyph_code,
    output      logic [tccw_pkg::ATTR_W-1:0]   color_attribute,
    output      logic                          last_of_run
);

    localparam int AW = tccw_pkg::ADDR_CALC_W;

    function automatic tccw_pkg::cmd_t make_cmd(
        input logic [tccw_pkg::CMD_W-1:0]  cmd,
        input logic [tccw_pkg::ROW_W-1:0]  row,
        input logic [tccw_pkg::COL_W-1:0]  col,
        input logic [tccw_pkg::BYTE_W-1:0] glyph,
        input logic [tccw_pkg::ATTR_W-1:0] attr
    );
        tccw_pkg::cmd_t c;
        logic [AW-1:0]  addr;
        addr = AW'(row) * AW'(SCREEN_COLUMNS) + AW'(col);
        c.command         = cmd;
        c.cell_index      = addr[tccw_pkg::INDEX_W-1:0];
        c.row_number      = row;
        c.column_number   = col;
        c.glyph_code      = glyph;
        c.color_attribute = attr;
        c.last_of_run     = 1'b0;
        return c;
    endfunction

    // Input register.
    logic                        s1_valid_reg;
    logic [tccw_pkg::BYTE_W-1:0] s1_byte_reg;

    // Cursor state.
    tccw_pkg::phase_t             phase_reg, phase_next;
    logic [tccw_pkg::COL_W-1:0]   col_reg, col_next;
    logic [tccw_pkg::ROW_W-1:0]   row_reg, row_next;

    // Result register: slot 0 is presented on the output.
    tccw_pkg::cmd_t slot_reg [3];
    logic [1:0]     cnt_reg;

    tccw_pkg::cmd_t run_cmd [3];
    logic [1:0]     run_cnt;

    logic out_fire;
    logic buf_free;
    logic s1_adv;
    logic scroll;
    logic [tccw_pkg::ROW_W-1:0] row_inc;
    logic clear_ok;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_fire  = out_valid && out_ready;
    assign buf_free  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_fire);
    assign s1_adv    = s1_valid_reg && buf_free;
    assign in_ready  = !s1_valid_reg || s1_adv;

    assign row_inc  = row_reg + 1'b1;
    assign scroll   = (row_inc >= tccw_pkg::ROW_W'(SCREEN_ROWS)) || (row_inc == '0);
    assign clear_ok = ({1'b0, col_reg} < 9'(SCREEN_COLUMNS));

    // Next cursor state.
    always_comb
    begin
        phase_next = tccw_pkg::PHASE_IDLE;
        col_next   = col_reg;
        row_next   = row_reg;
        case (phase_reg)
            tccw_pkg::PHASE_ESC:
            begin
                if (s1_byte_reg == tccw_pkg::BYTE_BRACKET)
                begin
                    phase_next = tccw_pkg::PHASE_BRACKET;
                end
            end
            tccw_pkg::PHASE_BRACKET:
            begin
                if (s1_byte_reg == tccw_pkg::BYTE_LETTER_G)
                begin
                    col_next = '0;
                end
            end
            default:
            begin
                if (s1_byte_reg == tccw_pkg::BYTE_ESC)
                begin
                    phase_next = tccw_pkg::PHASE_ESC;
                end
                else if (s1_byte_reg == tccw_pkg::BYTE_NEWLINE)
                begin
                    col_next = '0;
                    row_next = scroll ? tccw_pkg::ROW_W'(SCREEN_ROWS - 1) : row_inc;
                end
                else if (col_reg != tccw_pkg::COL_MAX)
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        endcase
    end

    // Command run for the byte in the input register.
    always_comb
    begin
        tccw_pkg::cmd_t erase_c;
        tccw_pkg::cmd_t draw_old_c;
        tccw_pkg::cmd_t draw_new_c;
        tccw_pkg::cmd_t scroll_c;
        erase_c    = make_cmd(tccw_pkg::CMD_WRITE, row_reg, col_reg,
                              tccw_pkg::BYTE_SPACE, tccw_pkg::ATTR_BLANK);
        draw_old_c = make_cmd(tccw_pkg::CMD_WRITE, row_reg, col_reg,
                              tccw_pkg::BYTE_CURSOR, tccw_pkg::ATTR_TEXT);
        draw_new_c = make_cmd(tccw_pkg::CMD_WRITE, row_next, col_next,
                              tccw_pkg::BYTE_CURSOR, tccw_pkg::ATTR_TEXT);
        scroll_c   = '0;
        scroll_c.command = tccw_pkg::CMD_SCROLL;

        run_cmd[0] = draw_new_c;
        run_cmd[1] = draw_new_c;
        run_cmd[2] = draw_new_c;
        run_cnt    = 2'd1;
        case (phase_reg)
            tccw_pkg::PHASE_ESC:
            begin
                if (s1_byte_reg == tccw_pkg::BYTE_BRACKET)
                begin
                    run_cnt = 2'd0;
                end
            end
            tccw_pkg::PHASE_BRACKET:
            begin
                if ((s1_byte_reg == tccw_pkg::BYTE_LETTER_K) && clear_ok)
                begin
                    run_cmd[0] = make_cmd(tccw_pkg::CMD_CLEAR, row_reg, col_reg,
                                          tccw_pkg::BYTE_SPACE, tccw_pkg::ATTR_BLANK);
                    run_cmd[1] = draw_old_c;
                    run_cnt    = 2'd2;
                end
            end
            default:
            begin
                run_cmd[0] = erase_c;
                if (s1_byte_reg == tccw_pkg::BYTE_ESC)
                begin
                    run_cnt = 2'd1;
                end
                else if (s1_byte_reg == tccw_pkg::BYTE_NEWLINE)
                begin
                    if (scroll)
                    begin
                        run_cmd[1] = scroll_c;
                        run_cnt    = 2'd3;
                    end
                    else
                    begin
                        run_cnt = 2'd2;
                    end
                end
                else
                begin
                    run_cmd[1] = make_cmd(tccw_pkg::CMD_WRITE, row_reg, col_reg,
                                          s1_byte_reg, tccw_pkg::ATTR_TEXT);
                    run_cnt    = 2'd3;
                end
            end
        endcase

        for (int i = 0; i < 3; i++)
        begin
            run_cmd[i].last_of_run = (2'(i + 1) == run_cnt);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            phase_reg    <= tccw_pkg::PHASE_IDLE;
            col_reg      <= '0;
            row_reg      <= '0;
            cnt_reg      <= 2'd0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_adv)
            begin
                phase_reg <= phase_next;
                col_reg   <= col_next;
                row_reg   <= row_next;
                cnt_reg   <= run_cnt;
            end
            else if (out_fire)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_byte_reg <= char_byte;
        end
        if (s1_adv)
        begin
            slot_reg[0] <= run_cmd[0];
            slot_reg[1] <= run_cmd[1];
            slot_reg[2] <= run_cmd[2];
        end
        else if (out_fire)
        begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

    assign command         = slot_reg[0].command;
    assign cell_index      = slot_reg[0].cell_index;
    assign row_number      = slot_reg[0].row_number;
    assign column_number   = slot_reg[0].column_number;
    assign glyph_code      = slot_reg[0].glyph_code;
    assign color_attribute = slot_reg[0].color_attribute;
    assign last_of_run     = slot_reg[0].last_of_run;

    // The cursor never leaves the screen vertically.
    assert property (@(posedge clk) disable iff (!rst_n)
        row_reg < tccw_pkg::ROW_W'(SCREEN_ROWS))
        else $error("cursor row beyond the last screen row");

    // The presented command is marked last exactly when it is the final one held.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_of_run == (cnt_reg == 2'd1)))
        else $error("last_of_run does not match the remaining run length");

    // Once the final command of a run is taken with nothing new loaded, output goes idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && last_of_run && !s1_adv) |=> !out_valid)
        else $error("output still valid after the end of a run");

    // The input register is never overwritten while it waits for the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !buf_free) |-> !in_ready)
        else $error("input register accepted a byte while stalled");

endmodule

`default_nettype wire
